// ----- rtl/rdc_pkg.sv -----
package rdc_pkg;

    // Sizing of the converter
    localparam int DIGIT_DEPTH = 32;
    localparam int VALUE_WIDTH = 31;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int RADIX_W     = 6;
    localparam int COUNT_W     = $clog2(DIGIT_DEPTH + 1);
    localparam int INDEX_W     = $clog2(DIGIT_DEPTH);
    localparam int BITCNT_W    = $clog2(VALUE_WIDTH);

    // Radix limits and character offsets
    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ALPHA_OFFSET  = CHAR_W'(55);

    // Configuration register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_LOAD
    } rdc_state_t;

    // Map a digit to its ASCII character
    function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DECIMAL_LIMIT)
        begin
            g = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            g = ALPHA_OFFSET + CHAR_W'(d);
        end
        return g;
    endfunction

    // Clamp a raw radix into the supported range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        if (r < RADIX_MIN)
        begin
            c = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            c = RADIX_MAX;
        end
        else
        begin
            c = r;
        end
        return c;
    endfunction

endpackage

// ----- rtl/radix_digit_converter.sv -----
// Converts a non-negative integer word into its digits in the radix held in
// the radix register (address 0; values below 2 act as 2, above 36 as 36),
// and returns one output word per digit, most significant first, with the
// digit, its ASCII character and a flag on the final digit. A zero word
// gives no output. One restoring divider is shared by all digits: each
// digit is found by the one-bit-per-cycle division over all VALUE_WIDTH
// dividend bits and then pushed onto the digit stack memory; the digits
// are then read back from the stack, each through a read state and a load
// state that waits while the output register is stalled. in_ready is high
// only between conversions; the final digit may still wait in the output
// register while the next word is taken.
module radix_digit_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rdc_pkg::PADDR_W-1:0]      paddr,
    input  logic [rdc_pkg::PDATA_W-1:0]      pwdata,
    output logic [rdc_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0]  value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]      digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]       digit_char,
    output logic                             last_digit
);
    import rdc_pkg::*;

    rdc_state_t              state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic [RADIX_W-1:0]      base_reg, base_next;
    logic [VALUE_WIDTH-1:0]  dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [BITCNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]      out_digit_reg, out_digit_next;
    logic                    out_last_reg, out_last_next;

    logic [DIGIT_W-1:0]      stack_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic                    push_en;
    logic                    rd_en;
    logic [INDEX_W-1:0]      push_idx;
    logic [INDEX_W-1:0]      rd_idx;

    logic                    cfg_wr;
    logic [DIGIT_W:0]        trial;
    logic [DIGIT_W:0]        trial_diff;
    logic                    trial_ge;
    logic                    out_free;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_RADIX)
        begin
            prdata = PDATA_W'(radix_reg);
        end
    end

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr)
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    // Shared divider step: shift one dividend bit into the partial remainder
    assign trial      = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, base_reg};
    assign trial_ge   = (trial >= {1'b0, base_reg});

    assign out_free = !out_valid_reg || out_ready;
    assign push_idx = count_reg[INDEX_W-1:0];
    assign rd_idx   = INDEX_W'(count_reg - COUNT_W'(1));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        in_ready       = 1'b0;
        push_en        = 1'b0;
        rd_en          = 1'b0;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    base_next    = clamp_radix(radix_reg);
                    dvd_next     = value;
                    rem_next     = '0;
                    bit_cnt_next = BITCNT_W'(VALUE_WIDTH - 1);
                    count_next   = '0;
                    if (value != '0)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next     = trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
                dvd_next     = {dvd_reg[VALUE_WIDTH-2:0], trial_ge};
                bit_cnt_next = bit_cnt_reg - BITCNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // Hold only as many digits as the stack has room for
                if (count_reg < COUNT_W'(DIGIT_DEPTH))
                begin
                    push_en    = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
                rem_next     = '0;
                bit_cnt_next = BITCNT_W'(VALUE_WIDTH - 1);
                if (dvd_reg == '0)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_POP_RD:
            begin
                rd_en      = 1'b1;
                count_next = count_reg - COUNT_W'(1);
                state_next = ST_POP_LOAD;
            end
            ST_POP_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = rd_data_reg;
                    out_last_next  = (count_reg == '0);
                    if (count_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_MIN;
            count_reg     <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            count_reg     <= count_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
    end

    // Digit stack memory
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[push_idx] <= rem_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_idx];
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_value = out_digit_reg;
    assign digit_char  = glyph_of(out_digit_reg);
    assign last_digit  = out_last_reg;

endmodule

// ----- rtl/rdc_checker.sv -----
module rdc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0]  value,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [rdc_pkg::DIGIT_W-1:0]      digit_value,
    input  logic [rdc_pkg::CHAR_W-1:0]       digit_char,
    input  logic                             last_digit
);
    import rdc_pkg::*;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digit_value)
            && $stable(last_digit)))
        else $error("output word changed while stalled");

    // A nonzero word keeps the converter busy for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (value != '0)) |=> !in_ready)
        else $error("converter ready right after taking a nonzero word");

    // Digits stay inside the widest radix
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_value < DIGIT_W'(RADIX_MAX)))
        else $error("digit beyond radix 36");

    // Character matches its digit
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char == glyph_of(digit_value)))
        else $error("character does not match digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_value (digit_value),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
);

// ----- test/rdc_digit_checker.sv -----
`timescale 1ns / 100ps

module rdc_digit_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdc_pkg::PADDR_W-1:0]       paddr,
    input  logic [rdc_pkg::PDATA_W-1:0]       pwdata,
    input  logic                              pready,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0]   value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [rdc_pkg::DIGIT_W-1:0]       digit_value,
    input  logic [rdc_pkg::CHAR_W-1:0]        digit_char,
    input  logic                              last_digit,
    output int                                mismatches,
    output int                                pending,
    output int                                digits_checked
);
    import rdc_pkg::*;

    localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'(4 * REG_RADIX);

    typedef struct packed {
        logic [DIGIT_W-1:0] dig;
        logic [CHAR_W-1:0]  chr;
        logic               last;
    } digit_word_t;

    digit_word_t        digits_due [$];
    digit_word_t        due_word;
    logic [RADIX_W-1:0] radix_shadow;

    // Saturate the raw register value into the supported base range
    function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
        begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX)
        begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    // Digits below ten map to '0'..'9', the rest to 'A' onward
    function automatic logic [CHAR_W-1:0] ascii_for(input logic [DIGIT_W-1:0] d);
        if (d < DECIMAL_LIMIT)
        begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return ALPHA_OFFSET + CHAR_W'(d);
    endfunction

    // Divide down, stack the remainders, then queue them most significant first
    task automatic predict_digits(input logic [VALUE_WIDTH-1:0] v,
                                  input logic [RADIX_W-1:0]     r);
        logic [DIGIT_W-1:0]     stack [DIGIT_DEPTH];
        logic [VALUE_WIDTH-1:0] rest;
        logic [VALUE_WIDTH-1:0] base;
        int                     depth;
        digit_word_t            w;
        depth = 0;
        rest  = v;
        base  = VALUE_WIDTH'(effective_base(r));
        while (rest != 0)
        begin
            // drop remainders once the stack is full
            if (depth < DIGIT_DEPTH)
            begin
                stack[depth] = DIGIT_W'(rest % base);
                depth++;
            end
            rest = rest / base;
        end
        while (depth > 0)
        begin
            depth--;
            w.dig  = stack[depth];
            w.chr  = ascii_for(w.dig);
            w.last = (depth == 0);
            digits_due.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Watch both channels and the register port on every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_shadow <= RADIX_MIN;
            digits_due.delete();
            pending = 0;
        end
        else
        begin
            // compare each output word against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (digits_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word: digit %0d char %0d last %0b",
                                              digit_value, digit_char, last_digit));
                end
                else
                begin
                    due_word = digits_due.pop_front();
                    digits_checked++;
                    if (digit_value !== due_word.dig)
                    begin
                        report_mismatch($sformatf("digit_value %0d, predicted %0d",
                                                  digit_value, due_word.dig));
                    end
                    if (digit_char !== due_word.chr)
                    begin
                        report_mismatch($sformatf("digit_char %0d, predicted %0d",
                                                  digit_char, due_word.chr));
                    end
                    if (last_digit !== due_word.last)
                    begin
                        report_mismatch($sformatf("last_digit %0b, predicted %0b",
                                                  last_digit, due_word.last));
                    end
                end
            end

            // predict digits for each accepted input word
            if (in_valid && in_ready)
            begin
                predict_digits(value, radix_shadow);
            end

            // track the radix register
            if (psel && penable && pwrite && pready && paddr == RADIX_ADDR)
            begin
                radix_shadow <= pwdata[RADIX_W-1:0];
            end

            pending = digits_due.size();
        end
    end

endmodule

// ----- test/tb_radix_digit_converter.sv -----
`timescale 1ns / 100ps

module tb_radix_digit_converter;
    import rdc_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 1100;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 38;
    localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'(4 * REG_RADIX);

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [DIGIT_W-1:0]     digit_value;
    logic [CHAR_W-1:0]      digit_char;
    logic                   last_digit;

    int mismatches;
    int pending;
    int digits_checked;
    int cycle_count;
    int words_sent;
    int settings_written;
    int stall_left;
    bit idling_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    radix_digit_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_value (digit_value),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    rdc_digit_checker u_digit_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_value    (digit_value),
        .digit_char     (digit_char),
        .last_digit     (last_digit),
        .mismatches     (mismatches),
        .pending        (pending),
        .digits_checked (digits_checked)
    );

    // Stall the output side in bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("ERROR: no progress within %0d cycles", LIMIT_CYCLES);
        $display("radix_digit_converter verification failed");
        $finish;
    end

    // Mostly short values, a quarter spanning the upper bits, a few zeros
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int                     len;
        logic [VALUE_WIDTH-1:0] v;
        if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(17, VALUE_WIDTH);
        end
        else
        begin
            len = $urandom_range(0, 16);
        end
        v = VALUE_WIDTH'($urandom);
        if (len == 0)
        begin
            v = '0;
        end
        else
        begin
            v = v & ((VALUE_WIDTH'(1) << len) - VALUE_WIDTH'(1));
            v[len-1] = 1'b1;
        end
        return v;
    endfunction

    // Setup cycle, then access cycle; upper data bits carry noise
    task automatic write_radix(input logic [RADIX_W-1:0] raw);
        logic [PDATA_W-1:0] data;
        data = PDATA_W'($urandom);
        data[RADIX_W-1:0] = raw;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIX_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    // Hold the word until accepted, then maybe idle before the next one
    task automatic send_word(input logic [VALUE_WIDTH-1:0] v);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop valid, drain all predicted digits, then wait out the block latency
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || !in_ready)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [RADIX_W-1:0] extremes [6];
        logic [RADIX_W-1:0] r;
        extremes = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        value    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radix, including the longest binary string
        send_word(VALUE_WIDTH'(5));
        send_word(VALUE_WIDTH'(32'h7FFF_FFFF));
        settle();

        // radix zero saturates to binary
        write_radix(6'd0);
        send_word(VALUE_WIDTH'(0));
        send_word(VALUE_WIDTH'(1));
        send_word(VALUE_WIDTH'(2));
        send_word(VALUE_WIDTH'(32'h2AAA_AAAA));
        settle();

        // top radix: digit and letter boundaries
        write_radix(6'd36);
        send_word(VALUE_WIDTH'(9));
        send_word(VALUE_WIDTH'(10));
        send_word(VALUE_WIDTH'(35));
        send_word(VALUE_WIDTH'(36));
        send_word(VALUE_WIDTH'(1295));
        send_word(VALUE_WIDTH'(32'h7FFF_FFFF));
        send_word(VALUE_WIDTH'(0));
        settle();

        // all-ones register saturates to 36
        write_radix(6'd63);
        send_word(VALUE_WIDTH'(35));
        send_word(VALUE_WIDTH'(1296));
        settle();

        // decimal around powers of ten
        write_radix(6'd10);
        send_word(VALUE_WIDTH'(9));
        send_word(VALUE_WIDTH'(10));
        send_word(VALUE_WIDTH'(999_999_999));
        send_word(VALUE_WIDTH'(1_000_000_000));
        send_word(VALUE_WIDTH'(32'h7FFF_FFFF));
        settle();

        // just outside the legal range on both sides
        write_radix(6'd1);
        send_word(VALUE_WIDTH'(3));
        settle();
        write_radix(6'd37);
        send_word(VALUE_WIDTH'(36));
        settle();

        // random phases; the last one runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                idling_on = 1'b0;
            end
            if (p % 3 == 0)
            begin
                r = extremes[$urandom_range(0, 5)];
            end
            else
            begin
                r = RADIX_W'($urandom_range(3, 35));
            end
            write_radix(r);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                send_word(random_value());
            end
            settle();
        end

        $display("Summary: %0d words converted over %0d radix settings, %0d digits compared.",
                 words_sent, settings_written, digits_checked);
        $display("Settings included saturating radix values below 2 and above 36.");
        if (mismatches == 0)
        begin
            $display("radix_digit_converter verification clean");
        end
        else
        begin
            $display("%0d mismatches found", mismatches);
            $display("radix_digit_converter verification failed");
        end
        $finish;
    end

endmodule
